[hdl/psi_pkg.sv]
package psi_pkg;

	localparam int DEF_COORD_WIDTH = 32;
	localparam int DEF_FRAC_BITS   = 16;
	localparam int TOL_WIDTH       = 17;
	localparam int TOL_RESET       = 655;

endpackage

[hdl/polyline_segment_intersection_unit.sv]
// Polyline against query segment intersection. Feed a polyline one vertex per
// item on s_axis (first_point in tuser, last_point in tlast) together with the
// query segment; each pair of consecutive vertices is tested against the query
// by solving the 2x2 line system exactly with wide integers, and the first
// segment that hits (t in [-eps, 1+eps), s in (-eps, 1+eps), eps = tolerance
// in Q.FRAC_BITS, nonzero determinant) is kept. The item carrying last_point
// produces one result on m_axis: hit in tuser, crossing point and the hit
// segment's endpoints in tdata (all zero when there is no hit). Products, the
// window bound and the division steps run on one shared wide adder under a
// small sequencer: products are formed one multiplier bit per cycle (seven
// products per tested segment that is not parallel) and the crossing point
// uses a restoring divider that makes one quotient bit per cycle. A hit adds
// two more products and two divisions, one of each per axis. s_axis_tready is
// low while an item is at work, and while a finished result cannot yet be
// placed because the previous one still waits on m_axis.
module polyline_segment_intersection_unit
	import psi_pkg::*;
#(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH,
	parameter int FRAC_BITS   = DEF_FRAC_BITS,
	localparam int IN_TW  = ((6 * COORD_WIDTH + 7) / 8) * 8,
	localparam int OUT_TW = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// tolerance register
	input  logic                 tolerance_we,
	input  logic [TOL_WIDTH-1:0] tolerance_wdata,
	// vertex items
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// point_x, point_y, query_start_x, query_start_y, query_end_x, query_end_y
	input  logic [IN_TW-1:0]     s_axis_tdata,
	// first_point
	input  logic                 s_axis_tuser,
	// last_point
	input  logic                 s_axis_tlast,
	// result items
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// cross_x, cross_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y
	output logic [OUT_TW-1:0]    m_axis_tdata,
	// hit
	output logic                 m_axis_tuser
);

	localparam int W   = COORD_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int DW  = W + 1;
	localparam int MB  = (DW > TOL_WIDTH + 1) ? DW : TOL_WIDTH + 1;
	localparam int QB  = W + 3;
	localparam int A1  = (3 * W > 2 * W + F) ? 3 * W : 2 * W + F;
	localparam int A2  = (A1 > 2 * W + TOL_WIDTH + 2) ? A1 : 2 * W + TOL_WIDTH + 2;
	localparam int WD  = A2 + 8;
	localparam int NC  = (MB > QB) ? MB : QB;
	localparam int CW  = $clog2(NC + 1);
	localparam int SW  = W + 5;

	localparam logic signed [SW-1:0] SAT_HI = {6'b000000, {(W - 1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = {6'b111111, {(W - 1){1'b0}}};

	// product program: three determinant-style pairs, eps*det, crossing product
	localparam logic [2:0] OP_DET_A = 3'd0;
	localparam logic [2:0] OP_DET_B = 3'd1;
	localparam logic [2:0] OP_TN_A  = 3'd2;
	localparam logic [2:0] OP_TN_B  = 3'd3;
	localparam logic [2:0] OP_SN_A  = 3'd4;
	localparam logic [2:0] OP_SN_B  = 3'd5;
	localparam logic [2:0] OP_EPS   = 3'd6;
	localparam logic [2:0] OP_CROSS = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_MUL, ST_NORM, ST_HI, ST_CMP,
		ST_DABS, ST_DSET, ST_DIV, ST_ADDP, ST_FINISH
	} state_t;

	state_t state_q;

	logic [TOL_WIDTH-1:0] tol_q;

	logic [W-1:0] prev_x_q, prev_y_q, cur_x_q, cur_y_q, p1x_q, p1y_q;
	logic         have_prev_q, found_q, last_q;
	logic [W-1:0] cross_x_q, cross_y_q;
	logic [W-1:0] sv_sx_q, sv_sy_q, sv_ex_q, sv_ey_q;

	logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q, rx_q, ry_q, dx_q, dy_q;
	logic signed [WD-1:0] det_q, tn_q, sn_q, lo_q, hi_q;
	logic signed [WD-1:0] acc_q, mcand_q, dv_q;
	logic [MB-1:0]        mplier_q;
	logic                 neg_q, qneg_q, axis_q;
	logic [2:0]           op_q;
	logic [CW-1:0]        cnt_q;
	logic [QB-1:0]        quot_q;

	logic              m_valid_q, m_hit_q;
	logic [6*W-1:0]    m_data_q;

	// shared adder
	logic signed [WD-1:0] alu_a, alu_b, alu_y;
	logic                 alu_sub;

	logic [W-1:0] in_px, in_py, in_qsx, in_qsy, in_qex, in_qey;
	logic         in_acc, do_test;
	logic signed [WD-1:0] ts, ss, lo_neg;
	logic                 cmp_hit;
	logic signed [SW-1:0] qext, csum, csat;
	logic                 out_free;

	assign in_px  = s_axis_tdata[W-1:0];
	assign in_py  = s_axis_tdata[2*W-1:W];
	assign in_qsx = s_axis_tdata[3*W-1:2*W];
	assign in_qsy = s_axis_tdata[4*W-1:3*W];
	assign in_qex = s_axis_tdata[5*W-1:4*W];
	assign in_qey = s_axis_tdata[6*W-1:5*W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	// a new polyline drops the old vertex and any earlier hit
	assign do_test       = !s_axis_tuser && have_prev_q && !found_q;
	assign out_free      = !m_valid_q || m_axis_tready;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_hit_q;
	assign m_axis_tdata  = OUT_TW'(m_data_q);

	always_comb begin
		alu_a   = acc_q;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_MUL: begin
				alu_b   = mcand_q;
				alu_sub = (cnt_q == CW'(MB - 1)) ^ neg_q;
			end
			ST_DIV: begin
				alu_b   = dv_q;
				alu_sub = 1'b1;
			end
			ST_HI: begin
				alu_a = det_q <<< F;
				alu_b = lo_q;
			end
			ST_DSET: begin
				alu_a = acc_q <<< 1;
				alu_b = det_q;
			end
			default: begin
				alu_a = acc_q;
			end
		endcase
		alu_y = alu_sub ? alu_a - alu_b : alu_a + alu_b;
	end

	// window test on scaled numerators against the now positive determinant
	always_comb begin
		ts      = tn_q <<< F;
		ss      = sn_q <<< F;
		lo_neg  = -lo_q;
		cmp_hit = (ts >= lo_neg) && (ts < hi_q) && (ss > lo_neg) && (ss < hi_q);
	end

	// crossing coordinate: p1 + rounded quotient, saturated
	always_comb begin
		qext = SW'({2'b00, quot_q});
		csum = (axis_q ? SW'(signed'(p1y_q)) : SW'(signed'(p1x_q)))
			+ (qneg_q ? -qext : qext);
		if (csum > SAT_HI) begin
			csat = SAT_HI;
		end else if (csum < SAT_LO) begin
			csat = SAT_LO;
		end else begin
			csat = csum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_WIDTH'(TOL_RESET);
		end else if (tolerance_we) begin
			tol_q <= tolerance_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			found_q     <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			cross_x_q   <= '0;
			cross_y_q   <= '0;
			sv_sx_q     <= '0;
			sv_sy_q     <= '0;
			sv_ex_q     <= '0;
			sv_ey_q     <= '0;
			m_valid_q   <= 1'b0;
			m_hit_q     <= 1'b0;
			op_q        <= OP_DET_A;
			cnt_q       <= '0;
			axis_q      <= 1'b0;
		end else begin
			// drop the taken result unless a new one replaces it this cycle
			if (m_valid_q && m_axis_tready && !(state_q == ST_FINISH && last_q)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cur_x_q <= in_px;
						cur_y_q <= in_py;
						last_q  <= s_axis_tlast;
						p1x_q   <= in_qsx;
						p1y_q   <= in_qsy;
						ax_q    <= DW'(signed'(in_px)) - DW'(signed'(prev_x_q));
						ay_q    <= DW'(signed'(in_py)) - DW'(signed'(prev_y_q));
						bx_q    <= DW'(signed'(in_qsx)) - DW'(signed'(in_qex));
						by_q    <= DW'(signed'(in_qsy)) - DW'(signed'(in_qey));
						rx_q    <= DW'(signed'(in_qsx)) - DW'(signed'(prev_x_q));
						ry_q    <= DW'(signed'(in_qsy)) - DW'(signed'(prev_y_q));
						dx_q    <= DW'(signed'(in_qex)) - DW'(signed'(in_qsx));
						dy_q    <= DW'(signed'(in_qey)) - DW'(signed'(in_qsy));
						if (s_axis_tuser) begin
							have_prev_q <= 1'b0;
							found_q     <= 1'b0;
						end
						op_q    <= OP_DET_A;
						state_q <= do_test ? ST_LOAD : ST_FINISH;
					end
				end
				ST_LOAD: begin
					cnt_q <= '0;
					case (op_q)
						OP_DET_A: begin
							acc_q <= '0; mcand_q <= WD'(ax_q); mplier_q <= MB'(by_q); neg_q <= 1'b0;
						end
						OP_DET_B: begin
							mcand_q <= WD'(bx_q); mplier_q <= MB'(ay_q); neg_q <= 1'b1;
						end
						OP_TN_A: begin
							acc_q <= '0; mcand_q <= WD'(rx_q); mplier_q <= MB'(by_q); neg_q <= 1'b0;
						end
						OP_TN_B: begin
							mcand_q <= WD'(bx_q); mplier_q <= MB'(ry_q); neg_q <= 1'b1;
						end
						OP_SN_A: begin
							acc_q <= '0; mcand_q <= WD'(ax_q); mplier_q <= MB'(ry_q); neg_q <= 1'b0;
						end
						OP_SN_B: begin
							mcand_q <= WD'(ay_q); mplier_q <= MB'(rx_q); neg_q <= 1'b1;
						end
						OP_EPS: begin
							acc_q <= '0; mcand_q <= det_q; mplier_q <= MB'(tol_q); neg_q <= 1'b0;
						end
						default: begin
							acc_q    <= '0;
							mcand_q  <= sn_q;
							mplier_q <= axis_q ? MB'(dy_q) : MB'(dx_q);
							neg_q    <= 1'b0;
						end
					endcase
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					// one multiplier bit per cycle, the top bit carries negative weight
					if (mplier_q[0]) begin
						acc_q <= alu_y;
					end
					mcand_q  <= mcand_q <<< 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q + 1'b1;
					if (cnt_q == CW'(MB - 1)) begin
						case (op_q)
							OP_DET_B: begin det_q <= mplier_q[0] ? alu_y : acc_q; end
							OP_TN_B:  begin tn_q  <= mplier_q[0] ? alu_y : acc_q; end
							OP_SN_B:  begin sn_q  <= mplier_q[0] ? alu_y : acc_q; end
							OP_EPS:   begin lo_q  <= mplier_q[0] ? alu_y : acc_q; end
							default:  begin end
						endcase
						case (op_q)
							OP_SN_B:  begin state_q <= ST_NORM; end
							OP_EPS:   begin state_q <= ST_HI; end
							OP_CROSS: begin state_q <= ST_DABS; end
							default: begin
								op_q    <= op_q + 1'b1;
								state_q <= ST_LOAD;
							end
						endcase
					end
				end
				ST_NORM: begin
					// parallel lines never hit; otherwise make the determinant positive
					if (det_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						if (det_q < 0) begin
							det_q <= -det_q;
							tn_q  <= -tn_q;
							sn_q  <= -sn_q;
						end
						op_q    <= OP_EPS;
						state_q <= ST_LOAD;
					end
				end
				ST_HI: begin
					hi_q    <= alu_y;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (cmp_hit) begin
						axis_q  <= 1'b0;
						op_q    <= OP_CROSS;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_DABS: begin
					qneg_q  <= acc_q < 0;
					acc_q   <= (acc_q < 0) ? -acc_q : acc_q;
					state_q <= ST_DSET;
				end
				ST_DSET: begin
					// round half away: (2|n| + det) / (2 det)
					acc_q   <= alu_y;
					dv_q    <= det_q <<< QB;
					quot_q  <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!alu_y[WD-1]) begin
						acc_q <= alu_y;
					end
					quot_q <= {quot_q[QB-2:0], !alu_y[WD-1]};
					dv_q   <= dv_q >>> 1;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CW'(QB - 1)) begin
						state_q <= ST_ADDP;
					end
				end
				ST_ADDP: begin
					if (!axis_q) begin
						cross_x_q <= csat[W-1:0];
						axis_q    <= 1'b1;
						state_q   <= ST_LOAD;
					end else begin
						cross_y_q <= csat[W-1:0];
						found_q   <= 1'b1;
						sv_sx_q   <= prev_x_q;
						sv_sy_q   <= prev_y_q;
						sv_ex_q   <= cur_x_q;
						sv_ey_q   <= cur_y_q;
						state_q   <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					prev_x_q    <= cur_x_q;
					prev_y_q    <= cur_y_q;
					have_prev_q <= 1'b1;
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						m_valid_q   <= 1'b1;
						m_hit_q     <= found_q;
						m_data_q    <= found_q
							? {sv_ey_q, sv_ex_q, sv_sy_q, sv_sx_q, cross_y_q, cross_x_q}
							: '0;
						have_prev_q <= 1'b0;
						found_q     <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[test/polyline_segment_intersection_checker.sv]
`default_nettype none

module polyline_segment_intersection_checker
	import psi_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 tolerance_we,
	input  wire logic [TOL_WIDTH-1:0] tolerance_wdata,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [191:0]         s_tdata,
	input  wire logic                 s_tuser,
	input  wire logic                 s_tlast,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [191:0]         m_tdata,
	input  wire logic                 m_tuser,
	output int                        errors,
	output int                        pending,
	output int                        results_seen,
	output int                        hits_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [191:0] wide_t;
	typedef struct packed {
		logic         hit;
		logic [191:0] coords; // cross_x, cross_y, seg start x/y, seg end x/y
	} crossing_t;

	localparam wide_t CMAX = 192'sd2147483647;
	localparam wide_t CMIN = -CMAX - 1;

	crossing_t            expected_crossings[$];
	logic [TOL_WIDTH-1:0] tol;
	logic [31:0]          prev_x, prev_y;
	bit                   have_prev, found;
	crossing_t            saved;

	function automatic wide_t widen(logic [31:0] v);
		return wide_t'($signed(v));
	endfunction

	// p1 + sn*d/det, rounded half away from zero, clamped to 32-bit range
	function automatic logic [31:0] crossing_coord(wide_t p1, wide_t d, wide_t sn, wide_t det);
		wide_t n, q, v;
		bit neg;
		n = sn * d;
		neg = n < 0;
		if (neg) n = -n;
		q = (2 * n + det) / (2 * det);
		if (neg) q = -q;
		v = p1 + q;
		if (v > CMAX) v = CMAX;
		if (v < CMIN) v = CMIN;
		return v[31:0];
	endfunction

	function automatic bit segment_hits(logic [191:0] d, logic [31:0] gx0, logic [31:0] gy0,
			output logic [31:0] cx, output logic [31:0] cy);
		wide_t q0, q1, q2, q3, ax, ay, bx, by, rx, ry, det, tn, sn, eps, lo, hi, ts, ss;
		q0 = widen(d[64 +: 32]);
		q1 = widen(d[96 +: 32]);
		q2 = widen(d[128 +: 32]);
		q3 = widen(d[160 +: 32]);
		ax = widen(d[0 +: 32]) - widen(gx0);
		ay = widen(d[32 +: 32]) - widen(gy0);
		bx = q0 - q2;
		by = q1 - q3;
		rx = q0 - widen(gx0);
		ry = q1 - widen(gy0);
		det = ax * by - bx * ay;
		tn = rx * by - bx * ry;
		sn = ax * ry - ay * rx;
		cx = '0;
		cy = '0;
		// parallel or degenerate
		if (det == 0) return 0;
		if (det < 0) begin
			det = -det;
			tn = -tn;
			sn = -sn;
		end
		eps = '0;
		eps[TOL_WIDTH-1:0] = tol;
		lo = -(eps * det);
		hi = (wide_t'(65536) + eps) * det;
		ts = tn <<< 16;
		ss = sn <<< 16;
		if (ts < lo || ts >= hi) return 0;
		if (ss <= lo || ss >= hi) return 0;
		cx = crossing_coord(q0, -bx, sn, det);
		cy = crossing_coord(q1, -by, sn, det);
		return 1;
	endfunction

	task automatic predict_vertex(logic [191:0] d, logic first, logic last);
		logic [31:0] cx, cy;
		if (first) begin
			have_prev = 0;
			found = 0;
		end
		if (have_prev && !found && segment_hits(d, prev_x, prev_y, cx, cy)) begin
			found = 1;
			saved = {1'b1, d[32 +: 32], d[0 +: 32], prev_y, prev_x, cy, cx};
		end
		prev_x = d[0 +: 32];
		prev_y = d[32 +: 32];
		have_prev = 1;
		if (last) begin
			expected_crossings.push_back(found ? saved : crossing_t'(0));
			have_prev = 0;
			found = 0;
		end
	endtask

	task automatic check_crossing(logic hit, logic [191:0] d);
		crossing_t exp_c;
		string names[6];
		names = '{"cross_x", "cross_y", "seg_start_x", "seg_start_y", "seg_end_x", "seg_end_y"};
		results_seen++;
		if (hit) hits_seen++;
		if (expected_crossings.size() == 0) begin
			errors++;
			if (errors <= 10) $display("%0t: result with nothing expected, hit %0b", $time, hit);
			return;
		end
		exp_c = expected_crossings.pop_front();
		if (exp_c.hit !== hit) begin
			errors++;
			if (errors <= 10)
				$display("%0t: hit expected %0b got %0b", $time, exp_c.hit, hit);
		end
		for (int i = 0; i < 6; i++) begin
			if (exp_c.coords[32*i +: 32] !== d[32*i +: 32]) begin
				errors++;
				if (errors <= 10)
					$display("%0t: %s expected %h got %h", $time, names[i],
						exp_c.coords[32*i +: 32], d[32*i +: 32]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol = TOL_RESET;
			prev_x = '0;
			prev_y = '0;
			have_prev = 0;
			found = 0;
			saved = '0;
			expected_crossings.delete();
			errors = 0;
			results_seen = 0;
			hits_seen = 0;
		end else begin
			if (tolerance_we) tol = tolerance_wdata;
			if (m_tvalid && m_tready) check_crossing(m_tuser, m_tdata);
			if (s_tvalid && s_tready) predict_vertex(s_tdata, s_tuser, s_tlast);
		end
		pending = expected_crossings.size();
	end

endmodule

`default_nettype wire

[test/polyline_segment_intersection_unit_tb.sv]
`default_nettype none

module polyline_segment_intersection_unit_tb;
	import psi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                 clk;
	logic                 arst_n;
	logic                 tolerance_we;
	logic [TOL_WIDTH-1:0] tolerance_wdata;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	// point_x, point_y, query_start_x, query_start_y, query_end_x, query_end_y
	logic [191:0]         s_axis_tdata;
	logic                 s_axis_tuser; // first_point
	logic                 s_axis_tlast; // last_point
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// cross_x, cross_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y
	logic [191:0]         m_axis_tdata;
	logic                 m_axis_tuser; // hit

	int errors, pending, results_seen, hits_seen;
	int vertices_sent;
	bit steady;          // no sender gaps while set
	logic [31:0] qsx, qsy, qex, qey; // query riding along with each vertex

	localparam logic [31:0] CMIN = 32'h8000_0000;
	localparam logic [31:0] CMAX = 32'h7fff_ffff;

	polyline_segment_intersection_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.tolerance_we   (tolerance_we),
		.tolerance_wdata(tolerance_wdata),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser)
	);

	polyline_segment_intersection_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.tolerance_we   (tolerance_we),
		.tolerance_wdata(tolerance_wdata),
		.s_tvalid       (s_axis_tvalid),
		.s_tready       (s_axis_tready),
		.s_tdata        (s_axis_tdata),
		.s_tuser        (s_axis_tuser),
		.s_tlast        (s_axis_tlast),
		.m_tvalid       (m_axis_tvalid),
		.m_tready       (m_axis_tready),
		.m_tdata        (m_axis_tdata),
		.m_tuser        (m_axis_tuser),
		.errors         (errors),
		.pending        (pending),
		.results_seen   (results_seen),
		.hits_seen      (hits_seen)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Hard stop well past the slowest legal run (about 650 items plus stalls).
	initial begin
		#20ms;
		$display("polyline_segment_intersection_unit_tb NOT OK");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// Result side: hold tready low at random, in stretches of varying length.
	initial begin
		bit free_run;
		int run_len;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			free_run = $urandom_range(0, 3) == 0;
			run_len = $urandom_range(50, 2000);
			repeat (run_len) begin
				@(posedge clk);
				m_axis_tready <= free_run ? 1'b1 : (pick_gap() == 0);
			end
		end
	end

	// Integer units to Q16.16.
	function automatic logic [31:0] fx(int v);
		return v <<< 16;
	endfunction

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return (int'($urandom_range(0, 40)) - 20) * 65536
				+ ($urandom_range(0, 1) ? int'($urandom_range(0, 65535)) : 0);
			1: return $urandom;
			default: begin
				case ($urandom_range(0, 3))
					0: return CMIN;
					1: return CMAX;
					2: return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	// Present one vertex with the current query; advance once it is taken.
	task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic first, logic last);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {qey, qex, qsy, qsx, y, x};
		s_axis_tuser  <= first;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		vertices_sent++;
	endtask

	task automatic set_query(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx, logic [31:0] by);
		qsx = ax;
		qsy = ay;
		qex = bx;
		qey = by;
	endtask

	// Drain all results, then let a vertex that yields nothing finish its work.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [TOL_WIDTH-1:0] v);
		tolerance_we    <= 1'b1;
		tolerance_wdata <= v;
		@(posedge clk);
		tolerance_we    <= 1'b0;
	endtask

	task automatic directed_polylines();
		set_query(fx(0), fx(0), fx(10), fx(0));
		// lone vertex carrying both first and last: no segment, no hit
		send_vertex(fx(1), fx(1), 1, 1);
		// plain crossing in the middle
		send_vertex(fx(5), fx(-5), 1, 0);
		send_vertex(fx(5), fx(5), 0, 1);
		// parallel to the query
		send_vertex(fx(0), fx(1), 1, 0);
		send_vertex(fx(10), fx(1), 0, 1);
		// two hitting segments: the first one is kept
		send_vertex(fx(2), fx(-1), 1, 0);
		send_vertex(fx(2), fx(1), 0, 0);
		send_vertex(fx(8), fx(-1), 0, 1);
		// segment starts on the query (t at 0), then ends on it (t at 1)
		send_vertex(fx(5), fx(0), 1, 0);
		send_vertex(fx(5), fx(5), 0, 1);
		send_vertex(fx(5), fx(-5), 1, 0);
		send_vertex(fx(5), fx(0), 0, 1);
		// crossing right at the query start (s at 0)
		send_vertex(fx(0), fx(-5), 1, 0);
		send_vertex(fx(0), fx(5), 0, 1);
		// no first marker after a last: still starts fresh, then forms a segment
		send_vertex(fx(7), fx(-3), 0, 0);
		send_vertex(fx(7), fx(3), 0, 1);
		// degenerate query
		set_query(fx(3), fx(3), fx(3), fx(3));
		send_vertex(fx(0), fx(0), 1, 0);
		send_vertex(fx(6), fx(6), 0, 1);
		// full-range diagonals
		set_query(CMIN, CMIN, CMAX, CMAX);
		send_vertex(CMIN, CMAX, 1, 0);
		send_vertex(CMAX, CMIN, 0, 1);
		set_query(CMAX, CMIN, CMIN, CMAX);
		send_vertex(CMIN, CMIN, 1, 0);
		send_vertex(CMAX, CMAX, 0, 0);
		send_vertex('1, 32'h0000_0001, 0, 1);
	endtask

	task automatic random_polylines(int count);
		int stop_at, n, mode;
		bit noise;
		logic [31:0] x, y;
		stop_at = vertices_sent + count;
		while (vertices_sent < stop_at) begin
			steady = $urandom_range(0, 3) == 0;
			mode = $urandom_range(0, 9) < 7 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
			noise = $urandom_range(0, 9) == 0;
			set_query(rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode));
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				x = rand_coord(mode);
				y = rand_coord(mode);
				// now and then land a vertex exactly on a query endpoint
				if ($urandom_range(0, 9) == 0) begin
					x = qsx;
					y = qsy;
				end
				if (noise) begin
					if ($urandom_range(0, 1))
						set_query(rand_coord(mode), rand_coord(mode),
							rand_coord(mode), rand_coord(mode));
					send_vertex(x, y, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end else begin
					send_vertex(x, y, i == 0, i == n - 1);
				end
			end
		end
		steady = 0;
	endtask

	initial begin
		logic [TOL_WIDTH-1:0] tol_steps[4];
		arst_n          = 0;
		tolerance_we    = 0;
		tolerance_wdata = '0;
		s_axis_tvalid   = 0;
		s_axis_tdata    = '0;
		s_axis_tuser    = 0;
		s_axis_tlast    = 0;
		vertices_sent   = 0;
		steady          = 0;
		set_query('0, '0, '0, '0);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases at the reset tolerance, then again with no slack
		directed_polylines();
		settle();
		write_tolerance('0);
		directed_polylines();
		settle();

		tol_steps = '{17'd655, 17'd65536, 17'h1ffff, 17'($urandom_range(1, 65535))};
		foreach (tol_steps[k]) begin
			write_tolerance(tol_steps[k]);
			random_polylines(150);
			settle();
		end

		$display("%0d vertices sent over five tolerance settings", vertices_sent);
		$display("%0d results checked, %0d of them hits", results_seen, hits_seen);
		if (errors == 0 && pending == 0) begin
			$display("polyline_segment_intersection_unit_tb OK");
		end else begin
			$display("polyline_segment_intersection_unit_tb NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
hdl/psi_pkg.sv
hdl/polyline_segment_intersection_unit.sv
test/polyline_segment_intersection_checker.sv
test/polyline_segment_intersection_unit_tb.sv
